FILE: rtl/ivec_pkg.sv
`default_nettype none

package ivec_pkg;

    typedef enum logic
    {
        FUNC_ENCODE = 1'b0,
        FUNC_DECODE = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        HELD_NONE  = 2'd0,
        HELD_PCT   = 2'd1,
        HELD_DIGIT = 2'd2
    } held_t;

    // bytes produced by one input beat, oldest in slot 0
    typedef struct packed
    {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } run_t;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam logic [7:0] DG_0 = 8'h30;
    localparam logic [7:0] DG_2 = 8'h32;
    localparam logic [7:0] DG_3 = 8'h33;
    localparam logic [7:0] DG_5 = 8'h35;
    localparam logic [7:0] DG_9 = 8'h39;
    localparam logic [7:0] DG_A = 8'h41;
    localparam logic [7:0] DG_B = 8'h42;
    localparam logic [7:0] DG_C = 8'h43;
    localparam logic [7:0] DG_D = 8'h44;

endpackage

`default_nettype wire

FILE: rtl/info_value_escape_codec.sv
// channel   handshake            beat payload
// -------   ------------------   ----------------------------------
// input     push / full          func, data_byte, value_last
// result    pop / empty          out_byte, run_last, value_end
//
// one input beat per cycle while the run queue is not full; it yields up to
// three result beats, one per cycle while pop drains them; the single-byte
// output register sets that rate, and an escaped byte in encode yields three
// each result beat is held in the run queue, then in the output register
// the run queue lets the front keep taking beats while results wait for pop
// reset clears the decoder hold, the run queue and the output valid flag
`default_nettype none

module info_value_escape_codec
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        func,
    input  wire logic [7:0]  data_byte,
    input  wire logic        value_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             value_end
);

    ivec_pkg::run_t wr_run;
    ivec_pkg::run_t rd_run;
    logic           wr_en;
    logic           rd_en;
    logic           q_valid;

    ivec_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .q_full     (full),
        .func       (func),
        .data_byte  (data_byte),
        .value_last (value_last),
        .wr_run     (wr_run),
        .wr_en      (wr_en)
    );

    ivec_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_run (wr_run),
        .rd_en  (rd_en),
        .full   (full),
        .valid  (q_valid),
        .rd_run (rd_run)
    );

    ivec_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_run     (rd_run),
        .q_rd      (rd_en),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .value_end (value_end)
    );

endmodule

`default_nettype wire

FILE: rtl/ivec_front.sv
`default_nettype none

module ivec_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic          q_full,
    input  wire logic          func,
    input  wire logic [7:0]    data_byte,
    input  wire logic          value_last,
    output ivec_pkg::run_t     wr_run,
    output logic               wr_en
);

    ivec_pkg::held_t held_count_reg;
    ivec_pkg::held_t held_count_next;
    logic [7:0]      held_digit_reg;
    logic [7:0]      held_digit_next;
    logic            accept;
    logic            fresh;
    logic [1:0]      cnt;
    logic [16:0]     enc;
    logic [8:0]      pair;
    logic            digit_ok;

    // {hit, first digit, second digit}
    function automatic logic [16:0] enc_code(input logic [7:0] b);
        logic [16:0] r;
        r = '0;
        unique case (b)
            ivec_pkg::CH_PCT:   r = {1'b1, ivec_pkg::DG_2, ivec_pkg::DG_5};
            ivec_pkg::CH_TAB:   r = {1'b1, ivec_pkg::DG_0, ivec_pkg::DG_9};
            ivec_pkg::CH_LF:    r = {1'b1, ivec_pkg::DG_0, ivec_pkg::DG_A};
            ivec_pkg::CH_CR:    r = {1'b1, ivec_pkg::DG_0, ivec_pkg::DG_D};
            ivec_pkg::CH_SP:    r = {1'b1, ivec_pkg::DG_2, ivec_pkg::DG_0};
            ivec_pkg::CH_COMMA: r = {1'b1, ivec_pkg::DG_2, ivec_pkg::DG_C};
            ivec_pkg::CH_SEMI:  r = {1'b1, ivec_pkg::DG_3, ivec_pkg::DG_B};
            ivec_pkg::CH_EQ:    r = {1'b1, ivec_pkg::DG_3, ivec_pkg::DG_D};
            default:            r = '0;
        endcase
        return r;
    endfunction

    // {hit, decoded byte}
    function automatic logic [8:0] pair_decode(input logic [7:0] d, input logic [7:0] e);
        logic [8:0] r;
        r = '0;
        unique case ({d, e})
            {ivec_pkg::DG_2, ivec_pkg::DG_5}: r = {1'b1, ivec_pkg::CH_PCT};
            {ivec_pkg::DG_2, ivec_pkg::DG_0}: r = {1'b1, ivec_pkg::CH_SP};
            {ivec_pkg::DG_2, ivec_pkg::DG_C}: r = {1'b1, ivec_pkg::CH_COMMA};
            {ivec_pkg::DG_0, ivec_pkg::DG_9}: r = {1'b1, ivec_pkg::CH_TAB};
            {ivec_pkg::DG_0, ivec_pkg::DG_A}: r = {1'b1, ivec_pkg::CH_LF};
            {ivec_pkg::DG_0, ivec_pkg::DG_D}: r = {1'b1, ivec_pkg::CH_CR};
            {ivec_pkg::DG_3, ivec_pkg::DG_B}: r = {1'b1, ivec_pkg::CH_SEMI};
            {ivec_pkg::DG_3, ivec_pkg::DG_D}: r = {1'b1, ivec_pkg::CH_EQ};
            default:                          r = '0;
        endcase
        return r;
    endfunction

    assign accept   = push && !q_full;
    assign enc      = enc_code(data_byte);
    assign pair     = pair_decode(held_digit_reg, data_byte);
    assign digit_ok = (data_byte == ivec_pkg::DG_2) || (data_byte == ivec_pkg::DG_0)
                   || (data_byte == ivec_pkg::DG_3);

    always_comb
    begin
        wr_run          = '0;
        cnt             = 2'd0;
        fresh           = 1'b0;
        held_count_next = held_count_reg;
        held_digit_next = held_digit_reg;

        if (func == ivec_pkg::FUNC_ENCODE)
        begin
            held_count_next = ivec_pkg::HELD_NONE;
            held_digit_next = '0;
            if (enc[16])
            begin
                wr_run.bytes[0] = ivec_pkg::CH_PCT;
                wr_run.bytes[1] = enc[15:8];
                wr_run.bytes[2] = enc[7:0];
                cnt = 2'd3;
            end
            else
            begin
                wr_run.bytes[0] = data_byte;
                cnt = 2'd1;
            end
        end
        else
        begin
            unique case (held_count_reg)
                ivec_pkg::HELD_PCT:
                begin
                    if (digit_ok)
                    begin
                        held_count_next = ivec_pkg::HELD_DIGIT;
                        held_digit_next = data_byte;
                    end
                    else
                    begin
                        held_count_next = ivec_pkg::HELD_NONE;
                        wr_run.bytes[0] = ivec_pkg::CH_PCT;
                        cnt   = 2'd1;
                        fresh = 1'b1;
                    end
                end
                ivec_pkg::HELD_DIGIT:
                begin
                    held_count_next = ivec_pkg::HELD_NONE;
                    held_digit_next = '0;
                    if (pair[8])
                    begin
                        wr_run.bytes[0] = pair[7:0];
                        cnt = 2'd1;
                    end
                    else
                    begin
                        wr_run.bytes[0] = ivec_pkg::CH_PCT;
                        wr_run.bytes[1] = held_digit_reg;
                        cnt   = 2'd2;
                        fresh = 1'b1;
                    end
                end
                default:
                begin
                    held_count_next = ivec_pkg::HELD_NONE;
                    held_digit_next = '0;
                    fresh = 1'b1;
                end
            endcase
        end

        // byte handled from idle, after any broken sequence
        if (fresh)
        begin
            if (data_byte == ivec_pkg::CH_PCT)
            begin
                held_count_next = ivec_pkg::HELD_PCT;
                held_digit_next = '0;
            end
            else
            begin
                wr_run.bytes[cnt] = data_byte;
                cnt = cnt + 2'd1;
            end
        end

        // flush on last beat of the value
        if (value_last)
        begin
            if (held_count_next != ivec_pkg::HELD_NONE && cnt != 2'd3)
            begin
                wr_run.bytes[cnt] = ivec_pkg::CH_PCT;
                cnt = cnt + 2'd1;
            end
            if (held_count_next == ivec_pkg::HELD_DIGIT && cnt != 2'd3)
            begin
                wr_run.bytes[cnt] = held_digit_next;
                cnt = cnt + 2'd1;
            end
            held_count_next = ivec_pkg::HELD_NONE;
            held_digit_next = '0;
        end

        wr_run.cnt  = cnt;
        wr_run.last = value_last;
    end

    assign wr_en = accept && (cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= ivec_pkg::HELD_NONE;
            held_digit_reg <= '0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            held_digit_reg <= held_digit_next;
        end
    end

    a_held_code: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd3)
        else $error("decoder hold count out of range");

    a_digit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg != ivec_pkg::HELD_DIGIT) |-> (held_digit_reg == 8'd0))
        else $error("held digit not cleared");

    a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && value_last) |=> (held_count_reg == ivec_pkg::HELD_NONE))
        else $error("hold not flushed after last beat");

endmodule

`default_nettype wire

FILE: rtl/ivec_fifo.sv
`default_nettype none

module ivec_fifo
#(
    parameter int DEPTH = 2
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire ivec_pkg::run_t  wr_run,
    input  wire logic            rd_en,
    output logic                 full,
    output logic                 valid,
    output ivec_pkg::run_t       rd_run
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ivec_pkg::run_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign valid  = (count_reg != '0);
    assign rd_run = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_run;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("run queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && !valid))
        else $error("run queue underflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("run queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/ivec_back.sv
`default_nettype none

module ivec_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire ivec_pkg::run_t q_run,
    output logic               q_rd,
    output logic               empty,
    input  wire logic          pop,
    output logic [7:0]         out_byte,
    output logic               run_last,
    output logic               value_end
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       load;
    logic       last_byte;

    assign load      = q_valid && (!out_valid_reg || pop);
    assign last_byte = (idx_reg == (q_run.cnt - 2'd1));
    assign q_rd      = load && last_byte;
    assign empty     = !out_valid_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = last_byte ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte  <= q_run.bytes[idx_reg];
            run_last  <= last_byte;
            value_end <= last_byte && q_run.last;
        end
    end

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (idx_reg < q_run.cnt))
        else $error("byte index past end of run");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> (idx_reg == 2'd0))
        else $error("byte index not reset between runs");

    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && value_end) |-> run_last)
        else $error("value end without run end");

endmodule

`default_nettype wire
